// File: rtl/losf_pkg.sv
package losf_pkg;

	// Fixed field widths
	localparam int ROW_LEN_W = 11;
	localparam int SIZE_W    = 11;
	localparam int POS_W     = 10;

	// Parameter defaults
	localparam int DEF_MAX_ROW_LENGTH = 1024;
	localparam int DEF_MAX_ROWS       = 1024;

	// Row length after reset
	localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 11'd1024;

	typedef struct packed {
		logic cell_open;
		logic frame_end;
	} in_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] square_size;
		logic [POS_W-1:0]  corner_col;
		logic [POS_W-1:0]  corner_row;
	} out_item_t;

endpackage

// File: rtl/losf_line_ram.sv
module losf_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port (read-before-write)
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/losf_core.sv
module losf_core #(
	parameter int MAX_ROW_LENGTH = 1024,
	parameter int MAX_ROWS       = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  losf_pkg::in_item_t             item,
	input  logic [losf_pkg::ROW_LEN_W-1:0] row_length,
	output losf_pkg::out_item_t            result
);
	import losf_pkg::*;

	localparam int CW   = $clog2(MAX_ROW_LENGTH);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int SW   = $clog2(MAX_ROW_LENGTH + 1);
	localparam int LW   = (CW + 1 > ROW_LEN_W) ? CW + 1 : ROW_LEN_W;
	localparam logic [LW-1:0] MAX_LEN  = LW'(MAX_ROW_LENGTH);
	localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] left_q;
	logic [SW-1:0] diag_q;
	logic [SW-1:0] best_size_q;
	logic [CW-1:0] best_col_q;
	logic [RW-1:0] best_row_q;
	logic          byp_q;
	logic [SW-1:0] byp_data_q;

	logic [SW-1:0] rd_data;
	logic [SW-1:0] up;
	logic [LW-1:0] len_ext;
	logic [LW-1:0] len_eff;
	logic [LW-1:0] col_inc;
	logic          row_end;
	logic          first;
	logic [SW-1:0] min_lu;
	logic [SW-1:0] min3;
	logic [SW-1:0] size;
	logic          better;
	logic [CW-1:0] col_next;
	logic [SW-1:0] res_size;
	logic [CW-1:0] res_col;
	logic [RW-1:0] res_row;

	// Previous-row sizes, read ahead at the next column
	losf_line_ram #(
		.DEPTH(MAX_ROW_LENGTH),
		.WIDTH(SW)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(col_q),
		.wr_data(size),
		.rd_addr(col_next),
		.rd_data(rd_data)
	);

	// Effective row length: zero counts as one, clamp to line depth
	always_comb begin
		len_ext = LW'(row_length);
		if (len_ext == '0) begin
			len_eff = LW'(1);
		end else if (len_ext > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = len_ext;
		end
		col_inc = LW'(col_q) + LW'(1);
		row_end = (col_inc >= len_eff);
	end

	// Square size ending at this cell
	always_comb begin
		up     = byp_q ? byp_data_q : rd_data;
		first  = (row_q == '0) || (col_q == '0);
		min_lu = (left_q < up) ? left_q : up;
		min3   = (min_lu < diag_q) ? min_lu : diag_q;
		if (first) begin
			size = SW'(item.cell_open);
		end else if (item.cell_open) begin
			size = min3 + SW'(1);
		end else begin
			size = '0;
		end
		better = (size > best_size_q);
	end

	// Next column, also the line read address
	always_comb begin
		if (!accept) begin
			col_next = col_q;
		end else if (item.frame_end || row_end) begin
			col_next = '0;
		end else begin
			col_next = col_inc[CW-1:0];
		end
	end

	// Best after this cell, taken on frame end
	always_comb begin
		res_size = better ? size : best_size_q;
		res_col  = better ? col_q : best_col_q;
		res_row  = better ? row_q : best_row_q;
		result.square_size = SIZE_W'(res_size);
		result.corner_col  = POS_W'(res_col);
		result.corner_row  = POS_W'(res_row);
	end

	// Position, neighbors and best so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_col_q  <= '0;
			best_row_q  <= '0;
			byp_q       <= 1'b0;
		end else begin
			// line write and read hit the same column on this edge
			byp_q <= accept && (col_next == col_q);
			if (accept) begin
				col_q <= col_next;
				if (item.frame_end) begin
					row_q       <= '0;
					left_q      <= '0;
					diag_q      <= '0;
					best_size_q <= '0;
					best_col_q  <= '0;
					best_row_q  <= '0;
				end else begin
					left_q      <= row_end ? '0 : size;
					diag_q      <= row_end ? '0 : up;
					best_size_q <= res_size;
					best_col_q  <= res_col;
					best_row_q  <= res_row;
					if (row_end && (row_q < LAST_ROW)) begin
						row_q <= row_q + RW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= size;
	end

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !item.frame_end && row_end |=> col_q == '0 && left_q == '0)
		else $error("column did not wrap at row end");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.frame_end |=> best_size_q == '0 && row_q == '0)
		else $error("frame state not cleared");

	a_best_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !item.frame_end |=> best_size_q >= $past(best_size_q))
		else $error("best size decreased within frame");

endmodule

// File: rtl/largest_open_square_finder_top.sv
// A result is shown in the cycle after its frame-end item is accepted.
// Throughput: one item per cycle while in_stall is low; the line memory is read ahead.
// in_stall rises only for a frame-end item while the previous result is still
// held by out_stall. Async reset clears position, neighbors, best and output
// valid and sets row_length to 1024; the line memory is not cleared.
module largest_open_square_finder_top #(
	parameter int MAX_ROW_LENGTH = losf_pkg::DEF_MAX_ROW_LENGTH,
	parameter int MAX_ROWS       = losf_pkg::DEF_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [losf_pkg::ROW_LEN_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  losf_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output losf_pkg::out_item_t            out_item
);
	import losf_pkg::*;

	logic [ROW_LEN_W-1:0] row_length_q;
	logic                 out_valid_q;
	out_item_t            out_item_q;
	out_item_t            result;
	logic                 accept;
	logic                 res_load;

	// Handshake
	assign in_stall  = out_valid_q && out_stall && in_item.frame_end;
	assign accept    = in_valid && !in_stall;
	assign res_load  = accept && in_item.frame_end;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Row length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
		end else if (cfg_we) begin
			row_length_q <= cfg_data;
		end
	end

	losf_core #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH),
		.MAX_ROWS      (MAX_ROWS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_item),
		.row_length(row_length_q),
		.result    (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_item_q <= result;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_item.frame_end |=> out_valid)
		else $error("frame end gave no result");

	a_open_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_item.frame_end && in_item.cell_open |=> out_item.square_size != '0)
		else $error("open frame-end cell gave zero size");

endmodule

// File: verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import losf_pkg::*;

	localparam int LINE_CELLS = DEF_MAX_ROW_LENGTH;
	localparam int ROW_LIMIT  = DEF_MAX_ROWS;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [ROW_LEN_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;

	largest_open_square_finder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	// Shadow copy of the square tracker
	logic [ROW_LEN_W-1:0] row_len_reg;
	logic [SIZE_W-1:0]    line_mem [LINE_CELLS];
	logic [SIZE_W-1:0]    left_q, diag_q, best_sz;
	logic [POS_W-1:0]     col_q, row_q, best_c, best_r;
	out_item_t            pending_squares[$];
	out_item_t            head_square;

	bit tx_pace, rx_pace;
	int fails, cells_sent, frames_checked, cfg_writes;

	// 125 MHz clock, 8 ns period
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int cells_per_row(input logic [ROW_LEN_W-1:0] value);
		if (value == 0) return 1;
		if (value > LINE_CELLS) return LINE_CELLS;
		return value;
	endfunction

	function automatic void clear_frame_state();
		left_q  = '0;
		diag_q  = '0;
		col_q   = '0;
		row_q   = '0;
		best_sz = '0;
		best_c  = '0;
		best_r  = '0;
	endfunction

	// Size of the largest open square ending at this cell; queue the best on frame end
	function automatic void predict_cell(input logic open, input logic ends_frame);
		int unsigned span, col;
		logic [SIZE_W-1:0] up, sz, m;
		span = cells_per_row(row_len_reg);
		col  = col_q;
		up   = line_mem[col];
		if (row_q == 0 || col == 0) begin
			sz = SIZE_W'(open);
		end else if (open) begin
			m  = (left_q < up) ? left_q : up;
			m  = (m < diag_q) ? m : diag_q;
			sz = m + 1'b1;
		end else begin
			sz = '0;
		end
		line_mem[col] = sz;
		diag_q = up;
		left_q = sz;
		if (sz > best_sz) begin
			best_sz = sz;
			best_c  = POS_W'(col);
			best_r  = row_q;
		end
		// row wrap, also when a new length already lies behind the column
		if (col + 1 >= span) begin
			col_q  = '0;
			left_q = '0;
			diag_q = '0;
			if (row_q < ROW_LIMIT - 1) row_q++;
		end else begin
			col_q = POS_W'(col + 1);
		end
		if (ends_frame) begin
			pending_squares.push_back('{square_size: best_sz, corner_col: best_c,
				corner_row: best_r});
			clear_frame_state();
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_squares.size() == 0) begin
				$display("%0t ns: unexpected result, expected none actual size %0d col %0d row %0d",
					$time, out_item.square_size, out_item.corner_col, out_item.corner_row);
				fails++;
			end else begin
				head_square = pending_squares.pop_front();
				check_field("square_size", head_square.square_size, out_item.square_size);
				check_field("corner_col", head_square.corner_col, out_item.corner_col);
				check_field("corner_row", head_square.corner_row, out_item.corner_row);
				frames_checked++;
			end
		end
	end

	// Receiver: random hold-off before each result
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = rx_pace ? $urandom_range(0, 14) : 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Sender: one cell, held until accepted; valid stays up for back-to-back cells
	task automatic push_cell(input logic open, input logic ends_frame);
		int gap;
		gap = tx_pace ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item  <= '{cell_open: open, frame_end: ends_frame};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_cell(open, ends_frame);
		cells_sent++;
	endtask

	// Stop sending and wait for every queued result, plus the output latency
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_squares.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_row_length(input logic [ROW_LEN_W-1:0] value);
		settle();
		cfg_data <= value;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		row_len_reg = value;
		cfg_writes++;
		repeat (2) @(posedge clk);
	endtask

	// Cells from a bit pattern, oldest cell in the top bit
	task automatic send_bits(input logic [63:0] pattern, input int count, input bit ends_frame);
		for (int i = count - 1; i >= 0; i--) push_cell(pattern[i], ends_frame && i == 0);
	endtask

	task automatic send_random_cells(input int count, input int pct, input bit ends_frame);
		for (int i = 0; i < count; i++)
			push_cell($urandom_range(0, 99) < pct, ends_frame && i == count - 1);
	endtask

	// A lone blocked cell, then a row of four blocked cells: no square at all
	task automatic test_empty_frame();
		tx_pace = 1;
		rx_pace = 1;
		send_bits(64'b0, 1, 1);
		send_bits(64'b0000, 4, 1);
	endtask

	// Widest row; only the last cell open, so the corner lands on the last column
	task automatic test_full_width();
		tx_pace = 0;
		write_row_length(11'd1024);
		for (int i = 0; i < LINE_CELLS; i++) push_cell(i == LINE_CELLS - 1, i == LINE_CELLS - 1);
	endtask

	// Length above the line size is clamped: cell 1024 starts row 1
	task automatic test_length_clamp();
		write_row_length(11'd2047);
		for (int i = 0; i <= LINE_CELLS; i++) push_cell(i == LINE_CELLS, i == LINE_CELLS);
	endtask

	// Length zero acts as one cell per row; then the true minimum
	task automatic test_short_rows();
		tx_pace = 1;
		write_row_length(11'd0);
		send_bits(64'b0110, 4, 1);
		write_row_length(11'd1);
		send_bits(64'b001, 3, 1);
	endtask

	task automatic test_squares();
		write_row_length(11'd4);
		send_bits(64'hFFFF, 16, 1);
		// blocked interior cells, ties resolved by first seen
		send_bits(64'b0111_1011_1111_1110, 16, 1);
		send_bits(64'b1100_1100_0011_0011, 16, 1);
		// frame end in the middle of a row, then a fresh frame
		send_bits(64'b111111, 6, 1);
		send_bits(64'b1111, 4, 1);
	endtask

	// Row length rewritten while a frame is in progress
	task automatic test_midframe_length();
		write_row_length(11'd6);
		send_bits(64'b111111_111, 9, 0);
		write_row_length(11'd2);  // column 3 is already past the new length
		send_bits(64'b11111, 5, 0);
		write_row_length(11'd5);
		send_bits(64'b1011111, 7, 1);
	endtask

	// More rows than the counter holds; the first open cell sits on the saturated row
	task automatic test_row_saturation();
		tx_pace = 0;
		write_row_length(11'd1);
		for (int i = 0; i < ROW_LIMIT + 3; i++) push_cell(i >= ROW_LIMIT + 1, i == ROW_LIMIT + 2);
	endtask

	task automatic test_random_frames();
		int goal, pick, span, count, pct;
		goal = cells_sent + 1750;
		while (cells_sent < goal) begin
			tx_pace = ($urandom_range(0, 9) < 6);
			rx_pace = ($urandom_range(0, 9) < 6);
			case ($urandom_range(0, 2))
				0: pct = 50;
				1: pct = 85;
				default: pct = 97;
			endcase
			if ($urandom_range(0, 1) == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) write_row_length(ROW_LEN_W'($urandom_range(1, 8)));
				else if (pick < 88) write_row_length(ROW_LEN_W'($urandom_range(9, 40)));
				else if (pick < 94) write_row_length(ROW_LEN_W'($urandom_range(1025, 2047)));
				else if (pick < 97) write_row_length(11'd0);
				else write_row_length(11'd1024);
			end
			span = cells_per_row(row_len_reg);
			if (span > 40) count = $urandom_range(1, 60);
			else count = span * $urandom_range(1, 12);
			// early frame end now and then
			if ($urandom_range(0, 6) == 0) count = $urandom_range(1, count);
			case ($urandom_range(0, 9))
				0: begin
					// back-to-back single-cell frames load the result path
					repeat ($urandom_range(3, 8)) send_random_cells(1, pct, 1);
				end
				1: begin
					send_random_cells($urandom_range(1, count), pct, 0);
					write_row_length(ROW_LEN_W'($urandom_range(1, 16)));
					send_random_cells($urandom_range(1, 40), pct, 1);
				end
				2: begin
					settle();
					send_random_cells(count, pct, 1);
				end
				default: begin
					send_random_cells(count, pct, 1);
				end
			endcase
		end
	endtask

	initial begin
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		out_stall = 1'b0;
		arst_n    = 1'b0;
		tx_pace   = 0;
		rx_pace   = 0;
		row_len_reg = ROW_LENGTH_RESET;
		foreach (line_mem[i]) line_mem[i] = '0;
		clear_frame_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_frame();
		test_full_width();
		test_length_clamp();
		test_short_rows();
		test_squares();
		test_midframe_length();
		test_row_saturation();
		test_random_frames();

		settle();
		repeat (5) @(posedge clk);
		fails += pending_squares.size();
		$display("Sent %0d cells in %0d checked frames with %0d row-length writes,",
			cells_sent, frames_checked, cfg_writes);
		$display("incl. length 0/1/1024/2047, mid-frame changes, row saturation, random stalls.");
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("tb: failure");
		$finish;
	end

endmodule

// File: largest_open_square_finder_top.f
rtl/losf_pkg.sv
rtl/losf_line_ram.sv
rtl/losf_core.sv
rtl/largest_open_square_finder_top.sv
verif/testbench.sv
